// ===== hw/rtl/scanline_triangle_fill_macros.svh =====
// assertion macros for the triangle fill block
`ifndef SCANLINE_TRIANGLE_FILL_MACROS_SVH
`define SCANLINE_TRIANGLE_FILL_MACROS_SVH
// property that holds whenever reset is released
`define STF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define STF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

// ===== hw/rtl/stf_pkg.sv =====
// shared types and constants for the triangle fill block
`timescale 1ns / 1ps
package stf_pkg;
  localparam int unsigned CoordW = 13;
  localparam int unsigned FixW   = 48;
  localparam int unsigned ColorW = 24;
  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic CmdDraw = 1'b0;
  localparam logic CmdRead = 1'b1;
  localparam logic KindDraw = 1'b0;
  localparam logic KindRead = 1'b1;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [FixW-1:0] fix_t;
endpackage

// ===== hw/rtl/stf_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module stf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== hw/rtl/stf_div.sv =====
// iterative signed divider for the 32.16 inverse slopes
`timescale 1ns / 1ps
module stf_div import stf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic signed [CoordW:0] dx_i,
  input  logic signed [CoordW:0] dy_i,
  output logic        done_o,
  output fix_t        quot_o
);
  localparam int unsigned NumW = CoordW + 17;
  localparam int unsigned DenW = CoordW + 1;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic            neg_q, busy_q;
  logic [4:0]      cnt_q;
  logic [DenW:0]   trial;
  logic [DenW-1:0] dx_mag, dy_mag;

  assign dx_mag = dx_i[CoordW] ? DenW'(-dx_i) : DenW'(dx_i);
  assign dy_mag = dy_i[CoordW] ? DenW'(-dy_i) : DenW'(dy_i);
  // restoring step, one quotient bit a cycle
  assign trial = {rem_q, num_q[NumW-1]} - {1'b0, den_q};
  always_comb begin
    rem_d = trial[DenW] ? {rem_q[DenW-2:0], num_q[NumW-1]} : trial[DenW-1:0];
    num_d = {num_q[NumW-2:0], ~trial[DenW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(NumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {dx_mag, 16'h0};
      rem_q <= '0;
      den_q <= dy_mag;
      neg_q <= dx_i[CoordW] ^ dy_i[CoordW];
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  // zero divisor gives zero slope
  assign quot_o = (den_q == '0) ? '0 :
                  neg_q ? -FixW'($signed({1'b0, num_q})) : FixW'($signed({1'b0, num_q}));
endmodule

// ===== hw/rtl/scanline_triangle_fill.sv =====
// scanline triangle fill: a read passes through StRead and StReadWait to StOut; a draw
// runs the slope divider for each edge in turn, then walks the rows writing span pixels
// throughput one command at a time; set by the single framebuffer port and slope divider
// reset: asynchronous active low; a clearing pass writes zero to all
// SCREEN_SIZE*SCREEN_SIZE pixels (one per cycle) before the first command is taken
`timescale 1ns / 1ps
module scanline_triangle_fill import stf_pkg::*; #(
  parameter int unsigned SCREEN_SIZE = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: vx0, vy0, vx1, vy1, vx2, vy2, red, green, blue, read_index (zero padded)
  input  logic [119:0] s_axis_tdata,
  // tuser: command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: pixel_value, pixels_written (zero padded)
  output logic [47:0]  m_axis_tdata,
  // tuser: result_kind
  output logic         m_axis_tuser
);
`include "scanline_triangle_fill_macros.svh"
  localparam int unsigned AddrW = $clog2(SCREEN_SIZE * SCREEN_SIZE);
  localparam int unsigned ColW  = $clog2(SCREEN_SIZE);
  localparam int unsigned Pixels = SCREEN_SIZE * SCREEN_SIZE;

  typedef enum logic [3:0] {
    StClear, StIdle, StRead, StReadWait, StDiv0, StDiv1, StDiv2,
    StRow, StSpan, StOut
  } state_e;
  state_e state_q;

  // input fields
  coord_t vx0, vy0, vx1, vy1, vx2, vy2;
  logic [ColorW-1:0] color_in;
  logic [15:0] read_index;
  assign vx0 = s_axis_tdata[12:0];
  assign vy0 = s_axis_tdata[25:13];
  assign vx1 = s_axis_tdata[38:26];
  assign vy1 = s_axis_tdata[51:39];
  assign vx2 = s_axis_tdata[64:52];
  assign vy2 = s_axis_tdata[77:65];
  assign color_in = {s_axis_tdata[85:78], s_axis_tdata[93:86], s_axis_tdata[101:94]};
  assign read_index = s_axis_tdata[117:102];

  // sorting network, three compare and swap steps
  coord_t ax, ay, bx, by, cx, cy, px, py, qx, qy, rx, ry, sx0, sy0, sx1, sy1, sx2, sy2;
  always_comb begin
    if (vy0 > vy1) begin
      ax = vx1; ay = vy1; bx = vx0; by = vy0;
    end else begin
      ax = vx0; ay = vy0; bx = vx1; by = vy1;
    end
    cx = vx2; cy = vy2;
    if (ay > cy) begin
      px = cx; py = cy; rx = ax; ry = ay;
    end else begin
      px = ax; py = ay; rx = cx; ry = cy;
    end
    qx = bx; qy = by;
    if (qy > ry) begin
      sx1 = rx; sy1 = ry; sx2 = qx; sy2 = qy;
    end else begin
      sx1 = qx; sy1 = qy; sx2 = rx; sy2 = ry;
    end
    sx0 = px; sy0 = py;
  end

  // latched triangle
  coord_t x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, y_q;
  logic [ColorW-1:0] color_q;
  logic [15:0] ridx_q;
  logic ridx_ok_q;
  fix_t s02_q, s01_q, s12_q, lx_q, sx_q;
  logic [CountW-1:0] count_q;
  logic [ColW:0] col_q, hi_q;
  logic [AddrW:0] clr_q;
  logic [47:0] out_data_q;
  logic out_kind_q;

  // divider shared by the long edge and both short edges
  logic div_start, div_done;
  logic signed [CoordW:0] div_dx, div_dy;
  fix_t div_q;
  stf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dx_i(div_dx), .dy_i(div_dy),
    .done_o(div_done), .quot_o(div_q)
  );
  always_comb begin
    unique case (state_q)
      StDiv1: begin
        div_dx = (CoordW+1)'(x1_q) - (CoordW+1)'(x0_q);
        div_dy = (CoordW+1)'(y1_q) - (CoordW+1)'(y0_q);
      end
      StDiv2: begin
        div_dx = (CoordW+1)'(x2_q) - (CoordW+1)'(x1_q);
        div_dy = (CoordW+1)'(y2_q) - (CoordW+1)'(y1_q);
      end
      default: begin
        div_dx = (CoordW+1)'(x2_q) - (CoordW+1)'(x0_q);
        div_dy = (CoordW+1)'(y2_q) - (CoordW+1)'(y0_q);
      end
    endcase
  end
  logic div_go_q;
  assign div_start = div_go_q;

  // rounding of the long and short edge x values, halves away from zero
  function automatic logic signed [FixW-17:0] rnd(fix_t v);
    fix_t m;
    m = v[FixW-1] ? -v : v;
    m = m + fix_t'(32768);
    return v[FixW-1] ? -m[FixW-1:16] : m[FixW-1:16];
  endfunction
  logic signed [FixW-17:0] ra, rb, lo, hi;
  logic row_on;
  logic [ColW:0] lo_c, hi_c;
  assign ra = rnd(lx_q);
  assign rb = rnd(sx_q);
  assign lo = (ra < rb) ? ra : rb;
  assign hi = (ra < rb) ? rb : ra;
  assign row_on = (y_q >= 0) && (y_q < $signed((CoordW+1)'(SCREEN_SIZE)));
  assign lo_c = (lo < 0) ? '0 : (lo > SCREEN_SIZE) ? (ColW+1)'(SCREEN_SIZE) : (ColW+1)'(lo);
  assign hi_c = (hi < 0) ? '0 : (hi > SCREEN_SIZE) ? (ColW+1)'(SCREEN_SIZE) : (ColW+1)'(hi);

  // framebuffer port
  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [ColorW-1:0] ram_wdata, ram_rdata;
  always_comb begin
    ram_we = 1'b0;
    ram_addr = AddrW'(ridx_q);
    ram_wdata = color_q;
    if (state_q == StClear) begin
      ram_we = 1'b1;
      ram_addr = clr_q[AddrW-1:0];
      ram_wdata = '0;
    end else if (state_q == StSpan) begin
      ram_we = 1'b1;
      ram_addr = AddrW'(32'(y_q[ColW-1:0]) * SCREEN_SIZE + 32'(col_q));
    end
  end
  stf_ram #(.Width(ColorW), .Depth(Pixels)) u_fb (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      div_go_q   <= 1'b0;
      out_kind_q <= KindDraw;
      out_data_q <= '0;
    end else begin
      div_go_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AddrW+1)'(Pixels - 1)) state_q <= StIdle;
        end
        StIdle: if (s_axis_tvalid) begin
          if (s_axis_tuser == CmdRead) begin
            state_q <= StRead;
          end else begin
            state_q  <= StDiv0;
            div_go_q <= 1'b1;
          end
        end
        StRead: state_q <= StReadWait;
        StReadWait: begin
          out_kind_q <= KindRead;
          out_data_q <= {7'd0, CountW'(0), ridx_ok_q ? ram_rdata : ColorW'(0)};
          state_q <= StOut;
        end
        StDiv0: if (div_done) begin
          state_q <= StDiv1; div_go_q <= 1'b1;
        end
        StDiv1: if (div_done) begin
          state_q <= StDiv2; div_go_q <= 1'b1;
        end
        StDiv2: if (div_done) state_q <= StRow;
        StRow: begin
          if (y_q >= y2_q) begin
            out_kind_q <= KindDraw;
            out_data_q <= {7'd0, count_q, ColorW'(0)};
            state_q <= StOut;
          end else if (row_on && hi_c > lo_c) begin
            state_q <= StSpan;
          end
        end
        StSpan: if (col_q + 1'b1 >= hi_q) state_q <= StRow;
        StOut: if (m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      x0_q <= sx0; y0_q <= sy0; x1_q <= sx1; y1_q <= sy1; x2_q <= sx2; y2_q <= sy2;
      y_q <= sy0;
      color_q <= color_in;
      ridx_q <= read_index;
      ridx_ok_q <= (32'(read_index) < 32'(Pixels));
      count_q <= '0;
      lx_q <= fix_t'(sx0) <<< 16;
      // with a flat top the short edge starts at the middle vertex
      sx_q <= (sy0 == sy1) ? (fix_t'(sx1) <<< 16) : (fix_t'(sx0) <<< 16);
    end
    if (div_done) begin
      if (state_q == StDiv0) s02_q <= div_q;
      if (state_q == StDiv1) s01_q <= div_q;
      if (state_q == StDiv2) s12_q <= div_q;
    end
    if (state_q == StRow && y_q < y2_q) begin
      if (row_on && hi_c > lo_c) begin
        col_q <= lo_c;
        hi_q <= hi_c;
      end else begin
        // advance edges, switch short edge at the middle vertex
        lx_q <= lx_q + s02_q;
        y_q <= y_q + 1'b1;
        if (y_q + 1'b1 == y1_q) sx_q <= fix_t'(x1_q) <<< 16;
        else sx_q <= sx_q + ((y_q < y1_q) ? s01_q : s12_q);
      end
    end
    if (state_q == StSpan) begin
      col_q <= col_q + 1'b1;
      if (count_q != CountMax) count_q <= count_q + 1'b1;
      if (col_q + 1'b1 >= hi_q) begin
        lx_q <= lx_q + s02_q;
        y_q <= y_q + 1'b1;
        if (y_q + 1'b1 == y1_q) sx_q <= fix_t'(x1_q) <<< 16;
        else sx_q <= sx_q + ((y_q < y1_q) ? s01_q : s12_q);
      end
    end
  end

  `STF_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid), "ready and valid both high")
  `STF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
    "result dropped")
  `STF_ASSERT_NEXT(a_read_kind, state_q == StReadWait, m_axis_tuser == KindRead,
    "read result kind wrong")
endmodule

// ===== verif/tb_scanline_triangle_fill.sv =====
// self-checking testbench for the scanline triangle fill block
`timescale 1ns / 1ps
module tb_scanline_triangle_fill import stf_pkg::*; ();

  localparam int          Screen     = 256;
  localparam int unsigned Pixels     = Screen * Screen;
  localparam int unsigned StallLimit = 250000;

  typedef struct {
    logic        kind;
    logic [23:0] pixel;
    logic [16:0] count;
  } fill_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  // shadow framebuffer and pending results
  logic [23:0]  shadow_fb [Pixels];
  fill_result_t pending_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned draws_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned pixels_drawn = 0;

  scanline_triangle_fill #(.SCREEN_SIZE(Screen)) dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // round a 16.16 value to the nearest column, halves away from zero
  function automatic longint round_col(input longint v);
    if (v >= 0) return (v + 32768) / 65536;
    return -((-v + 32768) / 65536);
  endfunction

  function automatic longint edge_step(input longint dx, input longint dy);
    if (dy == 0) return 0;
    return (dx * 65536) / dy;
  endfunction

  // walk rows top..bot-1, filling spans into the shadow framebuffer
  function automatic void fill_span_rows(input longint top, input longint bot,
                                         inout longint lx, input longint ls,
                                         inout longint sx, input longint ss,
                                         input logic [23:0] colour,
                                         inout int unsigned count);
    longint a, b, lo, hi;
    for (longint y = top; y < bot; y++) begin
      a  = round_col(lx);
      b  = round_col(sx);
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (y >= 0 && y < Screen) begin
        if (lo < 0) lo = 0;
        if (hi > Screen) hi = Screen;
        for (longint i = lo; i < hi; i++) begin
          shadow_fb[y * Screen + i] = colour;
          if (count < 131071) count++;
        end
      end
      lx += ls;
      sx += ss;
    end
  endfunction

  // expected result of one command, updating the shadow framebuffer on draws
  function automatic fill_result_t predict_fill(input logic cmd, input logic [119:0] d);
    fill_result_t r;
    longint xs[3], ys[3], t, lx, sx, s02, s01, s12;
    int unsigned count;
    logic [23:0] colour;
    r = '{kind: KindRead, pixel: '0, count: '0};
    if (cmd == CmdRead) begin
      r.pixel = shadow_fb[d[117:102]];
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      xs[k] = coord_t'(d[26*k +: 13]);
      ys[k] = coord_t'(d[26*k + 13 +: 13]);
    end
    colour = {d[85:78], d[93:86], d[101:94]};
    // sort by y, swapping only on strictly greater
    if (ys[0] > ys[1]) begin t = xs[0]; xs[0] = xs[1]; xs[1] = t;
      t = ys[0]; ys[0] = ys[1]; ys[1] = t; end
    if (ys[0] > ys[2]) begin t = xs[0]; xs[0] = xs[2]; xs[2] = t;
      t = ys[0]; ys[0] = ys[2]; ys[2] = t; end
    if (ys[1] > ys[2]) begin t = xs[1]; xs[1] = xs[2]; xs[2] = t;
      t = ys[1]; ys[1] = ys[2]; ys[2] = t; end
    s02 = edge_step(xs[2] - xs[0], ys[2] - ys[0]);
    s01 = edge_step(xs[1] - xs[0], ys[1] - ys[0]);
    s12 = edge_step(xs[2] - xs[1], ys[2] - ys[1]);
    count = 0;
    lx = xs[0] * 65536;
    sx = xs[0] * 65536;
    fill_span_rows(ys[0], ys[1], lx, s02, sx, s01, colour, count);
    sx = xs[1] * 65536;
    fill_span_rows(ys[1], ys[2], lx, s02, sx, s12, colour, count);
    r.kind  = KindDraw;
    r.count = count[16:0];
    pixels_drawn += count;
    return r;
  endfunction

  // send one command beat and record its expected result
  task automatic send_cmd(input logic cmd, input logic [119:0] d);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_fill(cmd, d));
    if (cmd == CmdRead) reads_sent++;
    else draws_sent++;
  endtask

  task automatic send_draw(input int x0, input int y0, input int x1, input int y1,
                           input int x2, input int y2, input logic [23:0] rgb);
    logic [119:0] d;
    d = '0;
    d[12:0]  = x0[12:0];
    d[25:13] = y0[12:0];
    d[38:26] = x1[12:0];
    d[51:39] = y1[12:0];
    d[64:52] = x2[12:0];
    d[77:65] = y2[12:0];
    d[85:78] = rgb[23:16];
    d[93:86] = rgb[15:8];
    d[101:94] = rgb[7:0];
    d[117:102] = 16'($urandom);
    send_cmd(CmdDraw, d);
  endtask

  task automatic send_read(input int unsigned index);
    logic [119:0] d;
    d = '0;
    d[101:0] = 102'({$urandom, $urandom, $urandom, $urandom});
    d[117:102] = index[15:0];
    send_cmd(CmdRead, d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // extremes, degenerate shapes, clipping on every side
  task automatic test_directed();
    send_read(0);
    send_read(65535);
    send_draw(10, 10, 10, 10, 10, 10, 24'hffffff);          // all on one row
    send_draw(0, 0, 40, 0, 20, 30, 24'h123456);             // flat top
    send_draw(20, 0, 0, 30, 40, 30, 24'h00ff00);            // flat bottom
    send_draw(-30, -20, 50, 5, 10, 40, 24'hff0000);         // left and top clip
    send_draw(240, 200, 300, 230, 250, 300, 24'h0000ff);    // right and bottom clip
    send_draw(-4096, 0, -4000, 5, -4090, 9, 24'hffffff);    // entirely left
    send_draw(4095, 100, 4000, 110, 4090, 120, 24'h000000); // entirely right
    send_draw(5, -4096, 50, -4090, 20, -4000, 24'habcdef);  // rows above screen
    send_draw(100, 100, 100, 150, 100, 200, 24'h777777);    // zero-width span
    send_draw(-4096, -4096, 4095, -4096, -4096, 4095, 24'h00ff00); // huge, but wholly off screen at the top left
    send_read(0);
    send_read(65535);
    send_draw(128, 20, 30, 200, 220, 180, 24'h000000);      // colour zero
    send_read(100 * Screen + 128);
    send_read(255);
    send_read(255 * Screen);
    drain();
  endtask

  // mostly small on-screen triangles, with sparse wide noise and reads
  task automatic test_random(input int unsigned n, input int unsigned s_pct,
                             input int unsigned r_pct);
    int bx, by, sel;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      bx = $urandom_range(0, 300) - 20;
      by = $urandom_range(0, 300) - 20;
      if (sel < 55) begin
        send_draw(bx, by, bx + $urandom_range(0, 80) - 40, by + $urandom_range(0, 80) - 40,
                  bx + $urandom_range(0, 80) - 40, by + $urandom_range(0, 80) - 40,
                  24'($urandom));
      end else if (sel < 63) begin
        // full-range x and y, but at most three rows tall
        by = $urandom_range(0, 8191) - 4096;
        if (by > 4092) by = 4092;
        send_draw($urandom_range(0, 8191) - 4096, by,
                  $urandom_range(0, 8191) - 4096, by + $urandom_range(0, 3),
                  $urandom_range(0, 8191) - 4096, by + $urandom_range(0, 3),
                  24'($urandom));
      end else if (sel < 64) begin
        send_draw($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  24'($urandom));
      end else begin
        send_read($urandom_range(0, 65535));
      end
    end
    drain();
  endtask

  // receiver holds off while reads keep coming, stalling the input side
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 400;
    for (int k = 0; k < 20; k++) send_read($urandom_range(0, 65535));
    drain();
  endtask

  // receiver handshake, result checking
  always @(posedge clk_i) begin
    fill_result_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser !== exp_r.kind || m_axis_tdata[23:0] !== exp_r.pixel ||
            m_axis_tdata[40:24] !== exp_r.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d pixel %h count %0d, got kind %0d pixel %h count %0d",
                     exp_r.kind, exp_r.pixel, exp_r.count,
                     m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[40:24]);
        end
      end
    end
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int unsigned i = 0; i < Pixels; i++) shadow_fb[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(190, 21, 72);
    test_random(190, 72, 21);
    test_random(190, 0, 0);
    test_backpressure();
    repeat (50) @(posedge clk_i);
    $display("covered %0d draws (%0d pixels filled) and %0d reads, with idling on",
             draws_sent, pixels_drawn, reads_sent);
    $display("both sides and a long output hold-off");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
